### sv/sha224_pkg.sv
// Package with types, constants and round functions for the SHA-512/224 hasher.
`default_nettype none
package sha224_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAw = 4;
  localparam int unsigned RoundTotal = 80;
  localparam int unsigned RoundW = 7;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLoad,
    StRound,
    StFold,
    StEmit
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } core_ctl_t;

  localparam logic [63:0] StartValues [8] = '{
    64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
    64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] sig0(input logic [63:0] x);
    sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sig1(input logic [63:0] x);
    sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

### sv/sha224_round.sv
// Iterative SHA-512 compression core: message schedule window and one round per cycle.
`default_nettype none
module sha224_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sha224_pkg::core_ctl_t ctl_i,
  input  wire logic [63:0]           blk_i [16],
  input  wire logic [63:0]           chain_i [8],
  output logic                       done_o,
  output logic [63:0]                vars_o [8]
);
  import sha224_pkg::*;

  logic [63:0] w_q [16];
  logic [63:0] w_d [16];
  logic [63:0] v_q [8];
  logic [63:0] v_d [8];
  logic [RoundW-1:0] rnd_q;
  logic [RoundW-1:0] rnd_d;
  logic run_q;
  logic run_d;
  logic [63:0] e, a, t1, t2, ch, mj, big0, big1, wnew;

  always_comb begin
    e    = v_q[4];
    a    = v_q[0];
    big1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
    ch   = (e & v_q[5]) ^ (~e & v_q[6]);
    t1   = v_q[7] + big1 + ch + RoundK[rnd_q] + w_q[0];
    big0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
    mj   = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + mj;
    wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
    w_d  = w_q;
    v_d  = v_q;
    rnd_d = rnd_q;
    run_d = run_q;
    done_o = 1'b0;
    if (ctl_i.start) begin
      w_d   = blk_i;
      v_d   = chain_i;
      rnd_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = wnew;
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      rnd_d  = rnd_q + 1'b1;
      if (rnd_q == RoundW'(RoundTotal - 1)) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      run_q <= 1'b0;
    end else begin
      rnd_q <= rnd_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  assign vars_o = v_d;

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> rnd_q < RoundW'(RoundTotal))
    else $error("round counter out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !run_q)
    else $error("start while compressing");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !run_q && rnd_q == RoundW'(RoundTotal))
    else $error("done without finishing rounds");
  a_busy_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> ctl_i.busy)
    else $error("rounds running while sequencer idle");
`endif
endmodule
`default_nettype wire

### sv/sha512_224_hasher.sv
// Top level of the SHA-512/224 hasher: word intake, padding, chaining and digest output.
// Usage: message words arrive on the input channel (in_valid_i, in_stall_o, in_item_i),
// each a big-endian 64-bit word with a count of valid leading bytes and a last flag.
// A word is transferred when valid is high and stall is low. Sixteen full words
// complete a block, which the shared round unit compresses at one round per cycle
// between a load state and a fold state, during which in_stall_o stays high.
// A non-last word that completes a block holds off the next word until that compression ends.
// On the last word the block writes the pad words one per cycle, pausing while a block compresses; it compresses one or
// two blocks, and then presents the four digest words on the output channel
// (out_valid_o, out_stall_i, out_item_o), index 0 first, digest_last on index 3.
// While the receiver stalls, the current digest word holds steady and no input is
// taken. Reset returns the chaining words to the SHA-512/224 initial values and
// clears the fill count and bit length; the block is then ready at once.
// After the fourth digest word the block is ready for a new message.
`default_nettype none
module sha512_224_hasher (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire sha224_pkg::in_item_t  in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output sha224_pkg::out_item_t      out_item_o
);
  import sha224_pkg::*;

  state_e state_q, state_d;
  logic [63:0] buf_q [16];
  logic [63:0] buf_d [16];
  logic [63:0] chain_q [8];
  logic [63:0] chain_d [8];
  logic [BufAw-1:0] fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [2:0] pstep_q, pstep_d;
  logic [1:0] oidx_q, oidx_d;
  logic fin_q, fin_d;
  logic pad80_q, pad80_d;
  logic [63:0] padw;
  logic [3:0] nb;
  logic push;
  logic [63:0] pw;
  core_ctl_t ctl;
  logic done;
  logic [63:0] vars [8];

  sha224_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .blk_i  (buf_q),
    .chain_i(chain_q),
    .done_o (done),
    .vars_o (vars)
  );

  always_comb begin
    nb = (in_item_i.valid_bytes > 4'd8 || !in_item_i.last_word) ? 4'd8 : in_item_i.valid_bytes;
    padw = 64'h0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) padw[63-8*i -: 8] = in_item_i.message_word[63-8*i -: 8];
      else if (4'(i) == nb) padw[63-8*i -: 8] = 8'h80;
    end
  end

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    chain_d = chain_q;
    fill_d  = fill_q;
    len_d   = len_q;
    pstep_d = pstep_q;
    oidx_d  = oidx_q;
    fin_d   = fin_q;
    pad80_d = pad80_q;
    push = 1'b0;
    pw   = 64'h0;
    ctl  = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    out_item_o.digest_word = (oidx_q == 2'd3) ? {32'h0, chain_q[3][63:32]}
                                              : chain_q[{1'b0, oidx_q}];
    out_item_o.word_index  = oidx_q;
    out_item_o.digest_last = (oidx_q == 2'd3);
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          len_d = len_q + {57'h0, nb, 3'b000};
          push  = 1'b1;
          pw    = (in_item_i.last_word && nb == 4'd8) ? in_item_i.message_word : padw;
          fin_d = in_item_i.last_word;
          pad80_d = in_item_i.last_word && nb == 4'd8;
        end
      end
      StPad: begin
        push = 1'b1;
        if (pad80_q) begin
          pw = 64'h8000000000000000;
          pad80_d = 1'b0;
        end else if (fill_q == 4'd15 && pstep_q == 3'd2) begin
          pw = len_q;
          fin_d = 1'b0;
          pstep_d = 3'd1;
        end else begin
          pw = 64'h0;
          if (fill_q == 4'd14) pstep_d = 3'd2;
        end
      end
      StLoad: begin
        ctl.start = 1'b1;
        ctl.busy  = 1'b1;
        state_d = StRound;
      end
      StRound: begin
        ctl.busy = 1'b1;
        if (done) state_d = StFold;
      end
      StFold: begin
        for (int i = 0; i < 8; i++) chain_d[i] = chain_q[i] + vars[i];
        if (fin_q || pad80_q) state_d = StPad;
        else if (fill_q == '0 && pstep_q == 3'd1) state_d = StEmit;
        else state_d = StIdle;
        pstep_d = 3'd0;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            state_d = StIdle;
            chain_d = StartValues;
            len_d   = '0;
            fill_d  = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (push) begin
      buf_d[fill_q] = pw;
      fill_d = fill_q + 1'b1;
      if (fill_q == 4'd15) state_d = StLoad;
      else if (fin_d || pad80_d) state_d = StPad;
      else state_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chain_q <= StartValues;
      fill_q  <= '0;
      len_q   <= '0;
      pstep_q <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      pad80_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      pstep_q <= pstep_d;
      oidx_q  <= oidx_d;
      fin_q   <= fin_d;
      pad80_q <= pad80_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> in_stall_o)
    else $error("input taken while busy");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StEmit)
    else $error("output outside emit");
  a_emit_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && oidx_q == 2'd3 |=> len_q == 64'h0 && fill_q == '0)
    else $error("state not cleared after digest");
`endif
endmodule
`default_nettype wire

### verif/tb_sha512_224_hasher.sv
// Self-checking testbench for the SHA-512/224 hasher: directed and random messages.
`timescale 1ns / 1ps
module tb_sha512_224_hasher;
  import sha224_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  sha512_224_hasher dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_item_i(in_item_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  localparam logic [63:0] HashK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };
  localparam logic [63:0] InitHash [8] = '{
    64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
    64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1
  };

  logic [63:0] chain [8];
  logic [63:0] blk [16];
  int unsigned blk_fill;
  logic [63:0] msg_bits;
  out_item_t digest_q [$];
  int unsigned errors = 0;
  bit hold_off = 1'b0;
  bit quiet_out = 1'b0;

  function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2, e, a;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 80; t++)
      w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
           + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
    for (int t = 0; t < 8; t++) v[t] = chain[t];
    for (int r = 0; r < 80; r++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & v[5]) ^ (~e & v[6]))
         + HashK[r] + w[r];
      t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain[t] += v[t];
  endtask

  task automatic append_word(logic [63:0] w);
    blk[blk_fill] = w;
    blk_fill = (blk_fill + 1) % 16;
    if (blk_fill == 0) compress_block();
  endtask

  task automatic restart_hash();
    for (int t = 0; t < 8; t++) chain[t] = InitHash[t];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_word(in_item_t it);
    int unsigned n;
    out_item_t d;
    logic [63:0] keep;
    n = it.valid_bytes;
    if (n > 8 || !it.last_word) n = 8;
    msg_bits += 64'(n * 8);
    if (!it.last_word) begin
      append_word(it.message_word);
      return;
    end
    if (n < 8) begin
      keep = (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
      append_word((it.message_word & keep) | (64'h80 << (56 - 8 * n)));
    end else begin
      append_word(it.message_word);
      append_word(64'h8000000000000000);
    end
    while (blk_fill != 14) append_word(64'd0);
    append_word(64'd0);
    append_word(msg_bits);
    for (int k = 0; k < 4; k++) begin
      d.digest_word = (k < 3) ? chain[k] : (chain[3] >> 32);
      d.word_index = 2'(k);
      d.digest_last = (k == 3);
      digest_q.push_back(d);
    end
    restart_hash();
  endtask

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  bit sender_gaps = 1'b1;

  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic lw);
    int unsigned g;
    g = sender_gaps ? gap_len() : 0;
    if (sender_gaps && $urandom_range(0, 1)) g = 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{message_word: w, valid_bytes: nb, last_word: lw};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word('{message_word: w, valid_bytes: nb, last_word: lw});
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_message(int unsigned full_words, logic [3:0] nb);
    for (int i = 0; i < full_words; i++) send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
    send_word(rand64(), nb, 1'b1);
  endtask

  task automatic wait_digests();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_word(64'd0, 4'd0, 1'b1);
    send_word(64'hffffffffffffffff, 4'd8, 1'b1);
    send_word(64'hffffffffffffffff, 4'd15, 1'b1);
    send_word(64'h0123456789abcdef, 4'd3, 1'b1);
    send_word(64'hffffffffffffffff, 4'd0, 1'b0);
    send_word(64'hffffffffffffffff, 4'd7, 1'b1);
    send_word(64'h0000000000000000, 4'd9, 1'b1);
  endtask

  task automatic test_block_boundaries();
    send_message(13, 4'd8);
    send_message(14, 4'd0);
    send_message(15, 4'd8);
    send_message(15, 4'd5);
    wait_digests();
  endtask

  task automatic test_backpressure();
    quiet_out = 1'b1;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(2, 4'd4);
        send_message(1, 4'd8);
        send_message(0, 4'd2);
      end
    join
    wait_digests();
    quiet_out = 1'b0;
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 130) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 5);
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_message(len, 4'($urandom_range(0, 15)));
      sent += len + 1;
      if ($urandom_range(0, 5) == 0) wait_digests();
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    int unsigned g;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else if (quiet_out) out_stall_i <= 1'b0;
      else begin
        g = gap_len();
        if (g != 0 && $urandom_range(0, 2) == 0) begin
          out_stall_i <= 1'b1;
          repeat (g - 1) @(negedge clk_i);
        end else out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest transfer %h", out_item_o);
      end else begin
        want = digest_q.pop_front();
        if (out_item_o.digest_word !== want.digest_word ||
            out_item_o.word_index !== want.word_index ||
            out_item_o.digest_last !== want.digest_last) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: expected %h/%0d/%0d actual %h/%0d/%0d",
                     want.digest_word, want.word_index, want.digest_last,
                     out_item_o.digest_word, out_item_o.word_index, out_item_o.digest_last);
        end
      end
    end
  end

  initial begin
    restart_hash();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_block_boundaries();
    test_backpressure();
    test_random_messages();
    wait_digests();
    repeat (300) @(negedge clk_i);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end
endmodule

### filelist.f
sv/sha224_pkg.sv
sv/sha224_round.sv
sv/sha512_224_hasher.sv
verif/tb_sha512_224_hasher.sv
